// ===== hdl/sha1_pkg.sv =====
`timescale 1ns / 1ps
package sha1_pkg;

  localparam int unsigned NumWords = 5;

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [5:0]  FILL_LAST  = 6'd63;
  localparam logic [5:0]  FILL_LEN   = 6'd56;
  localparam logic [6:0]  ROUND_LAST = 7'd79;
  localparam logic [2:0]  WORD_LAST  = 3'd4;

  localparam logic [NumWords-1:0][31:0] INIT_VECTOR = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K_CH    = 32'h5A827999;
  localparam logic [31:0] K_PAR_A = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ   = 32'h8F1BBCDC;
  localparam logic [31:0] K_PAR_B = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD80,
    S_ZERO,
    S_LEN,
    S_INIT,
    S_ROUND,
    S_FINISH,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    NXT_IDLE,
    NXT_PAD80,
    NXT_ZERO,
    NXT_OUT
  } after_e;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_e;

  typedef enum logic [1:0] {
    PH_CH,
    PH_PAR_A,
    PH_MAJ,
    PH_PAR_B
  } phase_e;

  typedef struct packed {
    logic      load_byte;
    byte_sel_e sel;
    logic      count_bits;
    logic      init_work;
    logic      round_step;
    phase_e    phase;
    logic      fold;
    logic      out_shift;
    logic      restart;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } dp_sts_t;

endpackage

// ===== hdl/sha1_dp.sv =====
`timescale 1ns / 1ps
module sha1_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha1_pkg::dp_cmd_t cmd_i,
  input  logic [7:0]        data_byte_i,
  output sha1_pkg::dp_sts_t sts_o,
  output logic [31:0]       digest_word_o
);
  import sha1_pkg::*;

  logic [NumWords-1:0][31:0] chain_q, chain_d;
  logic [63:0]               count_q, count_d;
  logic [5:0]                fill_q, fill_d;
  logic [15:0][31:0]         win_q, win_d;
  logic [31:0]               a_q, b_q, c_q, d_q, e_q;
  logic [31:0]               a_d, b_d, c_d, d_d, e_d;

  logic [7:0]  byte_in;
  logic [5:0]  len_shift;
  logic [31:0] f_val, k_val, sched_x, sched_new, tmp;

  assign len_shift = {3'd7 - fill_q[2:0], 3'b000};

  always_comb begin
    case (cmd_i.sel)
      SEL_DATA: byte_in = data_byte_i;
      SEL_PAD:  byte_in = PAD_BYTE;
      SEL_ZERO: byte_in = 8'h00;
      SEL_LEN:  byte_in = 8'(count_q >> len_shift);
      default:  byte_in = 8'h00;
    endcase
  end

  always_comb begin
    case (cmd_i.phase)
      PH_CH: begin
        f_val = (b_q & c_q) | (~b_q & d_q);
        k_val = K_CH;
      end
      PH_PAR_A: begin
        f_val = b_q ^ c_q ^ d_q;
        k_val = K_PAR_A;
      end
      PH_MAJ: begin
        f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
        k_val = K_MAJ;
      end
      PH_PAR_B: begin
        f_val = b_q ^ c_q ^ d_q;
        k_val = K_PAR_B;
      end
      default: begin
        f_val = b_q ^ c_q ^ d_q;
        k_val = K_PAR_B;
      end
    endcase
  end

  // win_q[15] holds the current schedule word; win_q[15-j] the word j rounds ahead
  assign sched_x   = win_q[13] ^ win_q[7] ^ win_q[2] ^ win_q[15];
  assign sched_new = {sched_x[30:0], sched_x[31]};
  assign tmp       = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + win_q[15];

  always_comb begin
    win_d = win_q;
    if (cmd_i.load_byte) begin
      win_d = {win_q[15][23:0], win_q[14:0], byte_in};
    end else if (cmd_i.round_step) begin
      win_d = {win_q[14:0], sched_new};
    end
  end

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    d_d = d_q;
    e_d = e_q;
    if (cmd_i.init_work) begin
      a_d = chain_q[0];
      b_d = chain_q[1];
      c_d = chain_q[2];
      d_d = chain_q[3];
      e_d = chain_q[4];
    end else if (cmd_i.round_step) begin
      a_d = tmp;
      b_d = a_q;
      c_d = {b_q[1:0], b_q[31:2]};
      d_d = c_q;
      e_d = d_q;
    end
  end

  always_comb begin
    chain_d = chain_q;
    count_d = count_q;
    fill_d  = fill_q;
    if (cmd_i.restart) begin
      chain_d = INIT_VECTOR;
      count_d = '0;
      fill_d  = '0;
    end else begin
      if (cmd_i.fold) begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        chain_d[4] = chain_q[4] + e_q;
      end else if (cmd_i.out_shift) begin
        chain_d = {32'h0, chain_q[NumWords-1:1]};
      end
      if (cmd_i.load_byte) begin
        fill_d = fill_q + 6'd1;
      end
      if (cmd_i.count_bits) begin
        count_d = count_q + 64'd8;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= INIT_VECTOR;
      count_q <= '0;
      fill_q  <= '0;
    end else begin
      chain_q <= chain_d;
      count_q <= count_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    e_q   <= e_d;
  end

  assign sts_o.fill    = fill_q;
  assign digest_word_o = chain_q[0];

endmodule

// ===== hdl/sha1_ctrl.sv =====
`timescale 1ns / 1ps
module sha1_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              byte_valid_i,
  input  logic              is_last_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        word_number_o,
  output logic              last_word_o,
  input  sha1_pkg::dp_sts_t sts_i,
  output sha1_pkg::dp_cmd_t cmd_o
);
  import sha1_pkg::*;

  state_e     state_q, state_d;
  after_e     after_q, after_d;
  logic [6:0] round_q, round_d;
  logic [2:0] word_q, word_d;
  logic       in_xfer, out_xfer, blk_full;

  assign in_xfer  = in_valid_i & in_ready_o;
  assign out_xfer = out_valid_o & out_ready_i;
  assign blk_full = sts_i.fill == FILL_LAST;

  always_comb begin
    state_d = state_q;
    after_d = after_q;
    round_d = round_q;
    word_d  = word_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (byte_valid_i && blk_full) begin
            state_d = S_INIT;
            after_d = is_last_i ? NXT_PAD80 : NXT_IDLE;
          end else if (is_last_i) begin
            state_d = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        state_d = blk_full ? S_INIT : S_ZERO;
        after_d = NXT_ZERO;
      end
      S_ZERO: begin
        if (sts_i.fill == FILL_LEN) begin
          state_d = S_LEN;
        end else if (blk_full) begin
          state_d = S_INIT;
          after_d = NXT_ZERO;
        end
      end
      S_LEN: begin
        if (blk_full) begin
          state_d = S_INIT;
          after_d = NXT_OUT;
        end
      end
      S_INIT: begin
        state_d = S_ROUND;
        round_d = '0;
      end
      S_ROUND: begin
        round_d = round_q + 7'd1;
        if (round_q == ROUND_LAST) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        case (after_q)
          NXT_IDLE:  state_d = S_IDLE;
          NXT_PAD80: state_d = S_PAD80;
          NXT_ZERO:  state_d = S_ZERO;
          NXT_OUT:   state_d = S_OUT;
          default:   state_d = S_IDLE;
        endcase
      end
      S_OUT: begin
        if (out_xfer) begin
          if (word_q == WORD_LAST) begin
            word_d  = '0;
            state_d = S_IDLE;
          end else begin
            word_d = word_q + 3'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.sel   = SEL_DATA;
    cmd_o.phase = PH_CH;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.load_byte  = in_valid_i & byte_valid_i;
        cmd_o.count_bits = in_valid_i & byte_valid_i;
      end
      S_PAD80: begin
        cmd_o.load_byte = 1'b1;
        cmd_o.sel       = SEL_PAD;
      end
      S_ZERO: begin
        cmd_o.load_byte = sts_i.fill != FILL_LEN;
        cmd_o.sel       = SEL_ZERO;
      end
      S_LEN: begin
        cmd_o.load_byte = 1'b1;
        cmd_o.sel       = SEL_LEN;
      end
      S_INIT: cmd_o.init_work = 1'b1;
      S_ROUND: begin
        cmd_o.round_step = 1'b1;
        if (round_q < 7'd20) begin
          cmd_o.phase = PH_CH;
        end else if (round_q < 7'd40) begin
          cmd_o.phase = PH_PAR_A;
        end else if (round_q < 7'd60) begin
          cmd_o.phase = PH_MAJ;
        end else begin
          cmd_o.phase = PH_PAR_B;
        end
      end
      S_FINISH: cmd_o.fold = 1'b1;
      S_OUT: begin
        out_valid_o     = 1'b1;
        cmd_o.out_shift = out_ready_i;
        cmd_o.restart   = out_ready_i && (word_q == WORD_LAST);
      end
      default: ;
    endcase
  end

  assign word_number_o = word_q;
  assign last_word_o   = word_q == WORD_LAST;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      after_q <= NXT_IDLE;
      round_q <= '0;
      word_q  <= '0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      round_q <= round_d;
      word_q  <= word_d;
    end
  end

endmodule

// ===== hdl/sha1_hash_engine.sv =====
// Throughput: one message byte per cycle until a 64-byte block fills, then compression
//   (load, 80 rounds, fold into the chaining words) through one round unit.
// A close: byte-wise padding and length, one or two compressions, then five digest
//   transfers, one per cycle while taken.
// Reset: chaining words to the initial vector, bit count and fill to zero, idle.
`timescale 1ns / 1ps
module sha1_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] byte_valid
  input  logic        s_axis_tlast,  // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,  // [2:0] word_number
  output logic        m_axis_tlast   // last_word
);
  import sha1_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sha1_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .byte_valid_i  (s_axis_tuser),
    .is_last_i     (s_axis_tlast),
    .in_ready_o    (s_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .word_number_o (m_axis_tuser),
    .last_word_o   (m_axis_tlast),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  sha1_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (s_axis_tdata),
    .sts_o         (sts),
    .digest_word_o (m_axis_tdata)
  );

endmodule

// ===== hdl/sha1_chk.sv =====
`timescale 1ns / 1ps
module sha1_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while digest pending");

  a_close_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input ready right after a closing transfer");

  a_word_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast
      |=> m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1))
    else $error("digest words out of sequence");

  a_tlast_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == sha1_pkg::WORD_LAST)))
    else $error("tlast not on fifth word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled digest word changed");

endmodule

bind sha1_hash_engine sha1_chk u_sha1_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
